// ----- src/ida_pkg.sv -----
// Shared types and constants for the interrupt duration accounting block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ida_pkg;

	localparam int TS_W  = 64;
	localparam int CNT_W = 32;

	localparam logic OP_ENTRY = 1'b0;
	localparam logic OP_EXIT  = 1'b1;

	// One start slot per (cpu, irq) pair.
	typedef struct packed {
		logic            vld;
		logic [TS_W-1:0] start;
	} slot_t;

	// One accounting entry per irq.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [TS_W-1:0]  total;
	} tot_t;

endpackage

`default_nettype wire

// ----- src/ida_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ida_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/irq_duration_accounting_top.sv -----
// Top level of the interrupt duration accounting block.
// Depends on ida_pkg and ida_ram (start slot memory and per-irq totals memory).
//
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid / in_ready | opcode, cpu_id, irq_number, timestamp_ns
// out     | output    | out_valid/out_ready | matched, duration_ns, accum_ns, call_count
//
// Each word is handled in order: read both memories, then compute the duration and
// update the start slot, then add into the irq total and load the output register.
// The read-modify-write of the two memories calls for these steps.
// After reset a clearing pass writes every start slot (2**(CPU_AW+IRQ_AW) of them,
// 2048 at the default sizes) and the totals; in_ready stays low during it.
// A new word is accepted while a result still waits in the output register; the
// final step stalls only if the previous result has not yet been taken.
`timescale 1ns / 1ps
`default_nettype none

module irq_duration_accounting_top
	import ida_pkg::*;
#(
	parameter int NUM_CPUS = 8,
	parameter int NUM_IRQS = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              opcode,
	input  wire logic [2:0]        cpu_id,
	input  wire logic [7:0]        irq_number,
	input  wire logic [TS_W-1:0]   timestamp_ns,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   matched,
	output logic      [TS_W-1:0]   duration_ns,
	output logic      [TS_W-1:0]   accum_ns,
	output logic      [CNT_W-1:0]  call_count
);

	localparam int CPU_AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int IRQ_AW = $clog2(NUM_IRQS);
	localparam int SLOT_AW = CPU_AW + IRQ_AW;
	localparam int SLOT_DEPTH = 1 << SLOT_AW;
	localparam int IRQ_DEPTH = 1 << IRQ_AW;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SUM
	} state_t;

	state_t state_q;

	logic [SLOT_AW-1:0] clr_q;
	logic               op_q;
	logic               cpu_ok_q;
	logic               irq_ok_q;
	logic [TS_W-1:0]    now_q;
	logic [SLOT_AW-1:0] slot_q;
	logic [IRQ_AW-1:0]  irq_idx_q;
	logic               hit_q;
	logic [TS_W-1:0]    delta_q;
	tot_t               tot_rd_q;

	logic [31:0]        cpu_ext;
	logic [31:0]        irq_ext;
	logic [SLOT_AW-1:0] slot_raddr;
	logic [IRQ_AW-1:0]  tot_raddr;
	logic               accept;

	logic               slot_we;
	logic [SLOT_AW-1:0] slot_waddr;
	slot_t              slot_wdata;
	slot_t              slot_rd;
	logic               tot_we;
	logic [IRQ_AW-1:0]  tot_waddr;
	tot_t               tot_wdata;
	tot_t               tot_rd;

	logic               hit;
	logic               pair_ok;
	tot_t               tot_new;
	logic               out_free;

	assign cpu_ext    = 32'(cpu_id);
	assign irq_ext    = 32'(irq_number);
	assign slot_raddr = {cpu_ext[CPU_AW-1:0], irq_ext[IRQ_AW-1:0]};
	assign tot_raddr  = irq_ext[IRQ_AW-1:0];

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	assign pair_ok = cpu_ok_q && irq_ok_q;
	assign hit     = pair_ok && (op_q == OP_EXIT) && slot_rd.vld;

	assign tot_new.total = tot_rd_q.total + delta_q;
	assign tot_new.count = tot_rd_q.count + CNT_W'(hit_q);

	// Memory write ports: the clearing pass owns them right after reset.
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = slot_q;
		slot_wdata = slot_t'(0);
		tot_we     = 1'b0;
		tot_waddr  = irq_idx_q;
		tot_wdata  = tot_new;
		case (state_q)
			ST_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				tot_we     = (clr_q[SLOT_AW-1:IRQ_AW] == '0);
				tot_waddr  = clr_q[IRQ_AW-1:0];
				tot_wdata  = tot_t'(0);
			end
			ST_LOOK: begin
				// An entry records a fresh start; a matched exit drops the mark.
				if (pair_ok && op_q == OP_ENTRY) begin
					slot_we          = 1'b1;
					slot_wdata.vld   = 1'b1;
					slot_wdata.start = now_q;
				end else if (hit) begin
					slot_we          = 1'b1;
					slot_wdata.vld   = 1'b0;
					slot_wdata.start = slot_rd.start;
				end
			end
			ST_SUM: begin
				tot_we = hit_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			// In the final step the valid flag is loaded below instead.
			if (out_valid && out_ready && state_q != ST_SUM) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SLOT_AW'(1);
					if (clr_q == SLOT_AW'(SLOT_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_q      <= opcode;
						cpu_ok_q  <= (cpu_ext < 32'(NUM_CPUS));
						irq_ok_q  <= (irq_ext < 32'(NUM_IRQS));
						now_q     <= timestamp_ns;
						slot_q    <= slot_raddr;
						irq_idx_q <= tot_raddr;
						state_q   <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					hit_q    <= hit;
					delta_q  <= hit ? (now_q - slot_rd.start) : '0;
					tot_rd_q <= tot_rd;
					state_q  <= ST_SUM;
				end
				ST_SUM: begin
					// The totals write repeats harmlessly while the output stalls.
					if (out_free) begin
						out_valid   <= 1'b1;
						matched     <= hit_q;
						duration_ns <= delta_q;
						accum_ns    <= irq_ok_q ? tot_new.total : '0;
						call_count  <= irq_ok_q ? tot_new.count : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	ida_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(SLOT_DEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.raddr(slot_raddr),
		.rdata(slot_rd)
	);

	ida_ram #(
		.WIDTH($bits(tot_t)),
		.DEPTH(IRQ_DEPTH)
	) u_tot_ram (
		.clk  (clk),
		.we   (tot_we),
		.waddr(tot_waddr),
		.wdata(tot_wdata),
		.raddr(tot_raddr),
		.rdata(tot_rd)
	);

endmodule

`default_nettype wire

// ----- tb/tb_irq_duration_accounting_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for irq_duration_accounting_top: directed table, then
// paired entry/exit traffic with and without idling, checked against a built-in model.
// Depends on ida_pkg and the RTL of the block only.

module tb_irq_duration_accounting_top;
	import ida_pkg::*;

	localparam int CPUS = 8;
	localparam int IRQS = 256;
	localparam int PHASE_WORDS = 550;
	localparam logic [TS_W-1:0] TS_MAX = '1;
	localparam logic [TS_W-1:0] TS_HALF = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic            op;
		logic [2:0]      cpu;
		logic [7:0]      irq;
		logic [TS_W-1:0] ts;
	} irq_event_t;

	typedef struct packed {
		logic             matched;
		logic [TS_W-1:0]  duration;
		logic [TS_W-1:0]  total;
		logic [CNT_W-1:0] count;
	} acct_t;

	typedef struct packed {
		irq_event_t ev;
		logic       known;
		acct_t      res;
	} dir_row_t;

	typedef struct packed {
		logic [2:0]      cpu;
		logic [7:0]      irq;
		logic [TS_W-1:0] ts;
	} open_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic opcode = OP_ENTRY;
	logic [2:0] cpu_id = '0;
	logic [7:0] irq_number = '0;
	logic [TS_W-1:0] timestamp_ns = '0;
	logic out_ready = 1'b0;
	wire in_ready;
	wire out_valid;
	wire matched;
	wire [TS_W-1:0] duration_ns;
	wire [TS_W-1:0] accum_ns;
	wire [CNT_W-1:0] call_count;

	// A typed-in result rides alongside its word, so it is sampled at the same edge.
	logic known_valid = 1'b0;
	acct_t known_res = '0;

	int send_idle_pct = 38;
	int recv_idle_pct = 62;
	int fail_cnt = 0;

	acct_t pending_results[$];
	dir_row_t directed_rows[$];
	open_pair_t open_pairs[$];

	// Accounting state as the block should hold it.
	bit [TS_W-1:0] start_stamp[CPUS][IRQS];
	bit start_mark[CPUS][IRQS];
	bit [TS_W-1:0] irq_accum_ns[IRQS];
	bit [CNT_W-1:0] irq_calls[IRQS];

	irq_duration_accounting_top #(
		.NUM_CPUS(CPUS),
		.NUM_IRQS(IRQS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.cpu_id(cpu_id),
		.irq_number(irq_number),
		.timestamp_ns(timestamp_ns),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.matched(matched),
		.duration_ns(duration_ns),
		.accum_ns(accum_ns),
		.call_count(call_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// At the default sizes every cpu and irq code is in range.
	function automatic acct_t account_event(irq_event_t ev);
		acct_t r;
		r = '0;
		if (ev.op == OP_ENTRY) begin
			start_stamp[ev.cpu][ev.irq] = ev.ts;
			start_mark[ev.cpu][ev.irq] = 1'b1;
		end else if (start_mark[ev.cpu][ev.irq]) begin
			r.duration = ev.ts - start_stamp[ev.cpu][ev.irq];
			start_mark[ev.cpu][ev.irq] = 1'b0;
			irq_accum_ns[ev.irq] += r.duration;
			irq_calls[ev.irq] += 1;
			r.matched = 1'b1;
		end
		r.total = irq_accum_ns[ev.irq];
		r.count = irq_calls[ev.irq];
		return r;
	endfunction

	task automatic check_field(input string field, input logic [TS_W-1:0] want,
		input logic [TS_W-1:0] got);
		if (got !== want) begin
			fail_cnt++;
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		acct_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = account_event({opcode, cpu_id, irq_number, timestamp_ns});
				if (known_valid)
					want = known_res;
				pending_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					fail_cnt++;
					$display("%0t ns: result word with none expected, actual %b %h %h %h",
						$time, matched, duration_ns, accum_ns, call_count);
				end else begin
					want = pending_results.pop_front();
					check_field("matched", 64'(want.matched), 64'(matched));
					check_field("duration_ns", want.duration, duration_ns);
					check_field("accum_ns", want.total, accum_ns);
					check_field("call_count", 64'(want.count), 64'(call_count));
				end
			end
		end
	end

	function automatic void add_row(input logic op, input logic [2:0] cpu, input logic [7:0] irq,
		input logic [TS_W-1:0] ts, input logic known, input logic m,
		input logic [TS_W-1:0] dur, input logic [TS_W-1:0] tot, input logic [CNT_W-1:0] cnt);
		directed_rows.push_back({op, cpu, irq, ts, known, m, dur, tot, cnt});
	endfunction

	// Presents one word after a random gap and returns at the edge that accepts it.
	task automatic drive_word(input irq_event_t ev, input logic known, input acct_t res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= ev.op;
		cpu_id <= ev.cpu;
		irq_number <= ev.irq;
		timestamp_ns <= ev.ts;
		known_valid <= known;
		known_res <= res;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_results.size() != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		irq_event_t ev;
		open_pair_t pair;
		logic [TS_W-1:0] clock_ns;
		logic [TS_W-1:0] delta;
		int idx;
		int roll;

		add_row(OP_EXIT, 0, 0, 64'd0, 1, 0, 0, 0, 0);
		add_row(OP_ENTRY, 0, 0, 64'd100, 1, 0, 0, 0, 0);
		add_row(OP_EXIT, 0, 0, 64'd350, 1, 1, 250, 250, 1);
		// The previous exit cleared the mark, so this one must not match.
		add_row(OP_EXIT, 0, 0, 64'd400, 1, 0, 0, 250, 1);
		add_row(OP_ENTRY, 7, 255, TS_MAX, 1, 0, 0, 0, 0);
		add_row(OP_EXIT, 7, 255, 64'd0, 1, 1, 1, 1, 1);
		add_row(OP_ENTRY, 3, 255, 64'd10, 1, 0, 0, 1, 1);
		add_row(OP_ENTRY, 3, 255, 64'd5, 1, 0, 0, 1, 1);
		// Exit stamp earlier than the newer start: duration and total both wrap.
		add_row(OP_EXIT, 3, 255, 64'd4, 1, 1, TS_MAX, 0, 2);
		add_row(OP_ENTRY, 5, 128, 64'h8000_0000_0000_0000, 1, 0, 0, 0, 0);
		add_row(OP_ENTRY, 6, 128, 64'd0, 1, 0, 0, 0, 0);
		add_row(OP_EXIT, 6, 128, TS_HALF, 1, 1, TS_HALF, TS_HALF, 1);
		add_row(OP_EXIT, 5, 128, TS_MAX, 1, 1, TS_HALF, TS_MAX - 1, 2);
		add_row(OP_EXIT, 5, 128, 64'd0, 1, 0, 0, TS_MAX - 1, 2);
		add_row(OP_ENTRY, 2, 8'h55, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0, 0);
		add_row(OP_EXIT, 2, 8'h55, 64'h5555_5555_5555_5555, 0, 0, 0, 0, 0);
		add_row(OP_ENTRY, 1, 8'hAA, 64'h5555_5555_5555_5555, 0, 0, 0, 0, 0);
		add_row(OP_EXIT, 1, 8'hAA, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0, 0);
		add_row(OP_ENTRY, 4, 1, 64'd1, 1, 0, 0, 0, 0);
		add_row(OP_EXIT, 4, 1, 64'd1, 1, 1, 0, 0, 1);
		add_row(OP_ENTRY, 4, 1, 64'd9, 0, 0, 0, 0, 0);
		add_row(OP_ENTRY, 0, 1, 64'd3, 0, 0, 0, 0, 0);
		add_row(OP_EXIT, 0, 1, 64'd8, 0, 0, 0, 0, 0);
		add_row(OP_EXIT, 4, 1, 64'd20, 0, 0, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			drive_word(directed_rows[i].ev, directed_rows[i].known, directed_rows[i].res);
		in_valid <= 1'b0;
		known_valid <= 1'b0;
		wait_drained();

		clock_ns = {$urandom, $urandom};
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 62 : 0;
			recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 38 : 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				roll = $urandom_range(99);
				if (open_pairs.size() > 0 && (roll < 45 || open_pairs.size() > 24)) begin
					idx = $urandom_range(open_pairs.size() - 1);
					pair = open_pairs[idx];
					open_pairs.delete(idx);
					if ($urandom_range(9) == 0)
						delta = {$urandom, $urandom};
					else
						delta = 64'($urandom_range(20000));
					ev = {OP_EXIT, pair.cpu, pair.irq, pair.ts + delta};
				end else if (roll < 90) begin
					// Half the entries land on a few irqs so their totals build up.
					ev = {OP_ENTRY, 3'($urandom_range(7)),
						8'($urandom_range(1) ? $urandom_range(15) : $urandom_range(255)),
						clock_ns};
					open_pairs.push_back({ev.cpu, ev.irq, ev.ts});
				end else begin
					// Stray entries and unpaired exits anywhere, with any stamp.
					ev = {1'($urandom_range(1)), 3'($urandom_range(7)),
						8'($urandom_range(255)), $urandom, $urandom};
				end
				clock_ns += 64'($urandom_range(1, 3000));
				if ($urandom_range(49) == 0)
					clock_ns = {$urandom, $urandom};
				drive_word(ev, 1'b0, '0);
			end
			// Hold the sender off until every result of this phase is back.
			in_valid <= 1'b0;
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
